@@ sv/hfr_pkg.sv @@
// Shared types, constants and helper functions of the hex frame receiver.
`timescale 1ns / 1ps

package hfr_pkg;

    localparam int PAYLOAD_MAX_DEF = 48;
    localparam int LINE_MAX_DEF    = 160;
    localparam int TAG_LEN         = 10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_MALFORMED = 2'd0;
    localparam logic [1:0] ERR_NUL       = 2'd1;
    localparam logic [1:0] ERR_OVERLONG  = 2'd2;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_FIRST,
        PH_DIGITS,
        PH_HEX
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_FETCH,
        ST_LOAD,
        ST_ACK,
        ST_HALT
    } state_t;

    // Line status that the parser reports to the control logic.
    typedef struct packed {
        logic line_empty;
        logic at_limit;
        logic shape_ok;
    } line_status_t;

    // Expected tag character at each position of the line.
    function automatic logic [7:0] tag_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h44;
            4'd1:    c = 8'h56;
            4'd2:    c = 8'h4d;
            4'd3:    c = 8'h47;
            4'd4:    c = 8'h50;
            4'd5:    c = 8'h55;
            4'd6:    c = 8'h5f;
            4'd7:    c = 8'h49;
            4'd8:    c = 8'h4e;
            4'd9:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Bit 4 flags a valid lowercase hex digit, bits 3:0 give its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, c[3:0]};
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

@@ sv/hfr_payload_ram.sv @@
// Payload byte memory with one write port and a registered read port.
`timescale 1ns / 1ps

module hfr_payload_ram #(
    parameter int DEPTH  = 48,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/hfr_line_parser.sv @@
// Per-character line parser: tag match, decimal offset and hex pair decoding.
`timescale 1ns / 1ps

module hfr_line_parser #(
    parameter int PAYLOAD_MAX = hfr_pkg::PAYLOAD_MAX_DEF,
    parameter int LINE_MAX    = hfr_pkg::LINE_MAX_DEF,
    parameter int CNT_W       = 6,
    parameter int ADDR_W      = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_en,
    input  logic [7:0]            in_byte,
    input  logic                  line_clear,
    output hfr_pkg::line_status_t status,
    output logic [63:0]           offset_value,
    output logic [CNT_W-1:0]      payload_count,
    output logic                  wr_en,
    output logic [ADDR_W-1:0]     wr_addr,
    output logic [7:0]            wr_data
);

    import hfr_pkg::*;

    localparam int LEN_W = $clog2(LINE_MAX);

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [63:0]        offset_reg, offset_next;
    logic               bad_reg, bad_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [3:0]         high_reg, high_next;
    logic               pending_reg, pending_next;

    logic [4:0]         hexv;
    logic               is_digit;
    logic [67:0]        offset_x10;

    assign hexv     = hex_nibble(in_byte);
    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    // Times ten as two shifted copies, plus the new digit; the top bits flag overflow.
    assign offset_x10 = {1'b0, offset_reg, 3'b000} + {3'b000, offset_reg, 1'b0}
                      + {64'd0, in_byte[3:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TAG;
            len_reg     <= '0;
            offset_reg  <= '0;
            bad_reg     <= 1'b0;
            count_reg   <= '0;
            high_reg    <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            offset_reg  <= offset_next;
            bad_reg     <= bad_next;
            count_reg   <= count_next;
            high_reg    <= high_next;
            pending_reg <= pending_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        offset_next  = offset_reg;
        bad_next     = bad_reg;
        count_next   = count_reg;
        high_next    = high_reg;
        pending_next = pending_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[ADDR_W-1:0];
        wr_data      = {high_reg, hexv[3:0]};

        if (line_clear)
        begin
            phase_next   = PH_TAG;
            len_next     = '0;
            offset_next  = '0;
            bad_next     = 1'b0;
            count_next   = '0;
            high_next    = '0;
            pending_next = 1'b0;
        end
        else if (byte_en)
        begin
            len_next = len_reg + 1'b1;
            if (!bad_reg)
            begin
                unique case (phase_reg)
                    PH_TAG:
                    begin
                        if (len_reg >= LEN_W'(TAG_LEN) || in_byte != tag_char(len_reg[3:0]))
                        begin
                            bad_next = 1'b1;
                        end
                        else if (len_reg == LEN_W'(TAG_LEN - 1))
                        begin
                            phase_next = PH_FIRST;
                        end
                    end
                    PH_FIRST, PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            if (offset_x10[67:64] != 4'd0)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                offset_next = offset_x10[63:0];
                                phase_next  = PH_DIGITS;
                            end
                        end
                        else if (in_byte == CH_SPACE && phase_reg == PH_DIGITS)
                        begin
                            phase_next = PH_HEX;
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                    PH_HEX:
                    begin
                        if (!hexv[4])
                        begin
                            bad_next = 1'b1;
                        end
                        else if (!pending_reg)
                        begin
                            if (count_reg >= CNT_W'(PAYLOAD_MAX))
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                high_next    = hexv[3:0];
                                pending_next = 1'b1;
                            end
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            count_next   = count_reg + 1'b1;
                            pending_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        bad_next = 1'b1;
                    end
                endcase
            end
        end
    end

    assign status.line_empty = (len_reg == '0);
    assign status.at_limit   = ({1'b0, len_reg} + 1'b1) >= (LEN_W + 1)'(LINE_MAX);
    assign status.shape_ok   = !bad_reg && phase_reg == PH_HEX && !pending_reg
                             && count_reg != '0;
    assign offset_value  = offset_reg;
    assign payload_count = count_reg;

endmodule

@@ sv/hex_frame_receiver_with_offset_check.sv @@
// Top level: word intake, frame checking, payload readout and result register.
// Ordinary bytes, carriage returns and empty lines are taken without a stall unless a held result blocks the input.
// After its newline, a valid line stalls the input while each payload byte passes through ST_FETCH and ST_LOAD,
// because each byte is a read of the payload memory followed by a load of the result register, and then for ST_ACK.
// An error result is registered and appears in the cycle after the offending word; the block then only drains words.
// Reset is asynchronous and clears the offset, the line state and the halt; memory is not cleared.
`timescale 1ns / 1ps

module hex_frame_receiver_with_offset_check #(
    parameter int PAYLOAD_MAX = hfr_pkg::PAYLOAD_MAX_DEF,
    parameter int LINE_MAX    = hfr_pkg::LINE_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [63:0] ack_offset,
    output logic [1:0]  error_code,
    output logic        last
);

    import hfr_pkg::*;

    localparam int CNT_W  = $clog2(PAYLOAD_MAX + 1);
    localparam int ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    state_t            state_reg, state_next;
    logic [63:0]       recv_reg, recv_next;
    logic [63:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]  emit_count_reg, emit_count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [7:0]        byte_reg, byte_next;
    logic [63:0]       ack_reg, ack_next;
    logic [1:0]        err_reg, err_next;
    logic              last_reg, last_next;

    line_status_t      status;
    logic [63:0]       offset_value;
    logic [CNT_W-1:0]  payload_count;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;

    logic              accept;
    logic              out_free;
    logic              byte_en;
    logic              line_clear;
    logic [64:0]       advanced;
    logic              frame_good;

    hfr_line_parser #(
        .PAYLOAD_MAX (PAYLOAD_MAX),
        .LINE_MAX    (LINE_MAX),
        .CNT_W       (CNT_W),
        .ADDR_W      (ADDR_W)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_en       (byte_en),
        .in_byte       (in_byte),
        .line_clear    (line_clear),
        .status        (status),
        .offset_value  (offset_value),
        .payload_count (payload_count),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    hfr_payload_ram #(
        .DEPTH  (PAYLOAD_MAX),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_RUN && state_reg != ST_HALT)
                    || (state_reg == ST_RUN && !out_free);
    assign accept   = in_valid && !in_stall;

    assign advanced   = {1'b0, recv_reg} + 65'(payload_count);
    assign frame_good = status.shape_ok && offset_value == recv_reg && !advanced[64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            recv_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            recv_reg      <= recv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        emit_count_reg <= emit_count_next;
        rd_idx_reg     <= rd_idx_next;
        kind_reg       <= kind_next;
        byte_reg       <= byte_next;
        ack_reg        <= ack_next;
        err_reg        <= err_next;
        last_reg       <= last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        recv_next       = recv_reg;
        sum_next        = sum_reg;
        emit_count_next = emit_count_reg;
        rd_idx_next     = rd_idx_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        byte_next       = byte_reg;
        ack_next        = ack_reg;
        err_next        = err_reg;
        last_next       = last_reg;
        byte_en         = 1'b0;
        line_clear      = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept && in_byte != CH_CR)
                begin
                    priority if (in_byte == CH_LF)
                    begin
                        if (!status.line_empty)
                        begin
                            if (frame_good)
                            begin
                                sum_next        = advanced[63:0];
                                emit_count_next = payload_count;
                                rd_idx_next     = '0;
                                line_clear      = 1'b1;
                                state_next      = ST_FETCH;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = KIND_ERROR;
                                byte_next      = '0;
                                ack_next       = '0;
                                err_next       = ERR_MALFORMED;
                                last_next      = 1'b1;
                                state_next     = ST_HALT;
                            end
                        end
                    end
                    else if (in_byte == CH_NUL)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_ERROR;
                        byte_next      = '0;
                        ack_next       = '0;
                        err_next       = ERR_NUL;
                        last_next      = 1'b1;
                        state_next     = ST_HALT;
                    end
                    else if (status.at_limit)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_ERROR;
                        byte_next      = '0;
                        ack_next       = '0;
                        err_next       = ERR_OVERLONG;
                        last_next      = 1'b1;
                        state_next     = ST_HALT;
                    end
                    else
                    begin
                        byte_en = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                // The read address was set last cycle; data is ready in ST_LOAD.
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_BYTE;
                    byte_next      = rd_data;
                    ack_next       = '0;
                    err_next       = '0;
                    last_next      = 1'b0;
                    rd_idx_next    = rd_idx_reg + 1'b1;
                    if (rd_idx_reg == emit_count_reg - 1'b1)
                    begin
                        state_next = ST_ACK;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ACK;
                    byte_next      = '0;
                    ack_next       = sum_reg;
                    err_next       = '0;
                    last_next      = 1'b1;
                    recv_next      = sum_reg;
                    state_next     = ST_RUN;
                end
            end
            ST_HALT:
            begin
                // Words are still taken so the sender never hangs, but they are dropped.
                state_next = ST_HALT;
            end
            default:
            begin
                state_next = ST_HALT;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = byte_reg;
    assign ack_offset   = ack_reg;
    assign error_code   = err_reg;
    assign last         = last_reg;

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH || state_reg == ST_LOAD) |-> rd_idx_reg < emit_count_reg)
        else $error("payload read index beyond the stored byte count");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_ERROR) |-> state_reg == ST_HALT)
        else $error("error result shown while the block is not halted");

    a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_reg == (kind_reg != KIND_BYTE)))
        else $error("last flag does not match the result kind");

    a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == ST_RUN)
        else $error("payload memory written during readout");

    a_ack_updates_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACK && out_free) |=> (recv_reg == ack_reg && state_reg == ST_RUN))
        else $error("acknowledged offset differs from the running offset");

endmodule
